>>> rtl/core/tcdd_pkg.sv
package tcdd_pkg;

  localparam int unsigned DefMaxCellsX = 32;
  localparam int unsigned DefMaxCellsY = 32;
  localparam int unsigned DefMaxCellsZ = 32;

  // Cell indices are carried in 8 bits, wider than the largest legal grid axis needs.
  localparam int unsigned IdxW  = 8;
  localparam int unsigned AccW  = 48;
  localparam int unsigned WordW = 4 * AccW;

  localparam logic [1:0] OpClear   = 2'd0;
  localparam logic [1:0] OpDeposit = 2'd1;
  localparam logic [1:0] OpRead    = 2'd2;

  localparam logic [2:0] RegCellsX  = 3'd0;
  localparam logic [2:0] RegCellsY  = 3'd1;
  localparam logic [2:0] RegCellsZ  = 3'd2;
  localparam logic [2:0] RegInvVol  = 3'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic                zero;
    logic [IdxW-1:0]     ix0;
    logic [IdxW-1:0]     ix1;
    logic [IdxW-1:0]     iy0;
    logic [IdxW-1:0]     iy1;
    logic [IdxW-1:0]     iz0;
    logic [IdxW-1:0]     iz1;
    logic [15:0]         gx;
    logic [15:0]         gy;
    logic [15:0]         gz;
    logic signed [23:0]  q;
    logic signed [23:0]  dx;
    logic signed [23:0]  dy;
    logic signed [23:0]  dz;
  } cmd_t;

  function automatic logic signed [AccW-1:0] sat48(input logic signed [49:0] v);
    logic signed [AccW-1:0] r;
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < -50'sh0_8000_0000_0000) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tcdd_ram.sv
module tcdd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tcdd_front.sv
module tcdd_front import tcdd_pkg::*; #(
  parameter int unsigned MaxCellsX = DefMaxCellsX,
  parameter int unsigned MaxCellsY = DefMaxCellsY,
  parameter int unsigned MaxCellsZ = DefMaxCellsZ
) (
  input  logic        [5:0]  cells_x_i,
  input  logic        [5:0]  cells_y_i,
  input  logic        [5:0]  cells_z_i,
  input  logic        [1:0]  operation_i,
  input  logic        [15:0] frac_x_i,
  input  logic        [15:0] frac_y_i,
  input  logic        [15:0] frac_z_i,
  input  logic signed [23:0] charge_i,
  input  logic signed [23:0] dipole_x_i,
  input  logic signed [23:0] dipole_y_i,
  input  logic signed [23:0] dipole_z_i,
  input  logic        [4:0]  read_cell_x_i,
  input  logic        [4:0]  read_cell_y_i,
  input  logic        [4:0]  read_cell_z_i,
  output logic               keep_o,
  output cmd_t               cmd_o
);

  function automatic logic [5:0] eff_cells(input logic [5:0] c, input int unsigned maxc);
    logic [5:0] r;
    if (c == 6'd0) begin
      r = 6'd1;
    end else if (32'(c) > maxc) begin
      r = 6'(maxc);
    end else begin
      r = c;
    end
    return r;
  endfunction

  logic [5:0]  ex, ey, ez;
  logic [21:0] sx, sy, sz;
  logic [6:0]  nx, ny, nz;
  logic        deposit;

  always_comb begin
    ex = eff_cells(cells_x_i, MaxCellsX);
    ey = eff_cells(cells_y_i, MaxCellsY);
    ez = eff_cells(cells_z_i, MaxCellsZ);
    sx = 22'(ex) * 22'(frac_x_i);
    sy = 22'(ey) * 22'(frac_y_i);
    sz = 22'(ez) * 22'(frac_z_i);
    nx = 7'(sx[21:16]) + 7'd1;
    ny = 7'(sy[21:16]) + 7'd1;
    nz = 7'(sz[21:16]) + 7'd1;
    deposit = (operation_i == OpDeposit);

    cmd_o      = '0;
    cmd_o.op   = operation_i;
    cmd_o.q    = charge_i;
    cmd_o.dx   = dipole_x_i;
    cmd_o.dy   = dipole_y_i;
    cmd_o.dz   = dipole_z_i;
    cmd_o.gx   = sx[15:0];
    cmd_o.gy   = sy[15:0];
    cmd_o.gz   = sz[15:0];
    cmd_o.zero = (32'(read_cell_x_i) >= MaxCellsX) || (32'(read_cell_y_i) >= MaxCellsY) ||
                 (32'(read_cell_z_i) >= MaxCellsZ);
    if (deposit) begin
      cmd_o.ix0 = IdxW'(sx[21:16]);
      cmd_o.iy0 = IdxW'(sy[21:16]);
      cmd_o.iz0 = IdxW'(sz[21:16]);
      // The upper neighbor wraps to cell zero at the grid edge.
      cmd_o.ix1 = (nx == 7'(ex)) ? '0 : IdxW'(nx);
      cmd_o.iy1 = (ny == 7'(ey)) ? '0 : IdxW'(ny);
      cmd_o.iz1 = (nz == 7'(ez)) ? '0 : IdxW'(nz);
    end else begin
      cmd_o.ix0 = IdxW'(read_cell_x_i);
      cmd_o.iy0 = IdxW'(read_cell_y_i);
      cmd_o.iz0 = IdxW'(read_cell_z_i);
    end
    keep_o = (operation_i == OpClear) || deposit || (operation_i == OpRead);
  end

endmodule

>>> rtl/core/tcdd_queue.sv
module tcdd_queue import tcdd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

>>> rtl/core/tcdd_back.sv
module tcdd_back import tcdd_pkg::*; #(
  parameter int unsigned MaxCellsX = DefMaxCellsX,
  parameter int unsigned MaxCellsY = DefMaxCellsY,
  parameter int unsigned MaxCellsZ = DefMaxCellsZ
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [31:0]            inv_cell_volume_i,
  input  cmd_t                   cmd_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   init_o,
  output logic                   result_valid_o,
  output logic signed [AccW-1:0] charge_density_o,
  output logic signed [AccW-1:0] polar_x_o,
  output logic signed [AccW-1:0] polar_y_o,
  output logic signed [AccW-1:0] polar_z_o
);

  localparam int unsigned Cells = MaxCellsX * MaxCellsY * MaxCellsZ;
  localparam int unsigned AW    = $clog2(Cells);

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StW    = 3'd3;
  localparam logic [2:0] StM1   = 3'd4;
  localparam logic [2:0] StM2   = 3'd5;
  localparam logic [2:0] StWr   = 3'd6;
  localparam logic [2:0] StRo   = 3'd7;

  logic [2:0]  state_q, state_d;
  logic        init_q, init_d;
  logic [2:0]  vert_q, vert_d;
  logic [AW-1:0] cnt_q, cnt_d;
  cmd_t        cmd_q;

  logic [32:0] p1_q;
  logic [16:0] wz_q;
  logic [24:0] w_q;
  logic signed [32:0]     t_q [4];
  logic signed [AccW-1:0] d_q [4];

  logic [IdxW-1:0] xi, yi, zi;
  logic [16:0]     wx, wy, wz;
  logic [AW-1:0]   addr;
  logic            we;
  logic [WordW-1:0] wdata, rdata;
  logic signed [AccW-1:0] old [4];
  logic signed [AccW-1:0] sum [4];
  logic signed [23:0]     val [4];
  logic [49:0]            wprod;

  always_comb begin
    xi = vert_q[0] ? cmd_q.ix1 : cmd_q.ix0;
    yi = vert_q[1] ? cmd_q.iy1 : cmd_q.iy0;
    zi = vert_q[2] ? cmd_q.iz1 : cmd_q.iz0;
    wx = vert_q[0] ? 17'(cmd_q.gx) : 17'h10000 - 17'(cmd_q.gx);
    wy = vert_q[1] ? 17'(cmd_q.gy) : 17'h10000 - 17'(cmd_q.gy);
    wz = vert_q[2] ? 17'(cmd_q.gz) : 17'h10000 - 17'(cmd_q.gz);
    wprod = 50'(p1_q) * 50'(wz_q);
    val[0] = cmd_q.q;
    val[1] = cmd_q.dx;
    val[2] = cmd_q.dy;
    val[3] = cmd_q.dz;
    old[0] = rdata[4*AccW-1:3*AccW];
    old[1] = rdata[3*AccW-1:2*AccW];
    old[2] = rdata[2*AccW-1:AccW];
    old[3] = rdata[AccW-1:0];
    for (int k = 0; k < 4; k++) begin
      sum[k] = sat48(50'(old[k]) + 50'(d_q[k]));
    end
    if (state_q == StClr) begin
      addr  = cnt_q;
      wdata = '0;
    end else begin
      addr  = AW'((AW'(xi) * AW'(MaxCellsY) + AW'(yi)) * AW'(MaxCellsZ) + AW'(zi));
      wdata = {sum[0], sum[1], sum[2], sum[3]};
    end
    we = (state_q == StClr) || ((state_q == StWr) && (cmd_q.op == OpDeposit));
  end

  tcdd_ram #(.Width(WordW), .Depth(Cells)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    vert_d  = vert_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    case (state_q)
      StClr: begin
        cnt_d = cnt_q + AW'(1);
        if (32'(cnt_q) == Cells - 1) begin
          state_d = StIdle;
          init_d  = 1'b0;
        end
      end
      StIdle: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          vert_d = 3'd0;
          cnt_d  = '0;
          if (cmd_i.op == OpClear) begin
            state_d = StClr;
          end else if (cmd_i.op == OpDeposit) begin
            state_d = StRd;
          end else begin
            state_d = StWr;
          end
        end
      end
      StRd: state_d = StW;
      StW:  state_d = StM1;
      StM1: state_d = StM2;
      StM2: state_d = StWr;
      StWr: begin
        if (cmd_q.op != OpDeposit) begin
          // A read comes through here with the write enable off.
          state_d = StRo;
        end else begin
          vert_d  = vert_q + 3'd1;
          state_d = (vert_q == 3'd7) ? StIdle : StRd;
        end
      end
      StRo: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      init_q  <= 1'b1;
      vert_q  <= 3'd0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      vert_q  <= vert_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == StRd) begin
      p1_q <= 33'(wx) * 33'(wy);
      wz_q <= wz;
    end
    if (state_q == StW) begin
      w_q <= wprod[48:24];
    end
    for (int k = 0; k < 4; k++) begin
      if (state_q == StM1) begin
        t_q[k] <= 33'((50'(val[k]) * $signed({25'd0, w_q})) >>> 16);
      end
      if (state_q == StM2) begin
        d_q[k] <= sat48(50'((66'(t_q[k]) * $signed({34'd0, inv_cell_volume_i})) >>> 16));
      end
    end
  end

  logic show;
  assign show             = (state_q == StRo) && !cmd_q.zero;
  assign init_o           = init_q;
  assign result_valid_o   = (state_q == StRo);
  assign charge_density_o = show ? old[0] : '0;
  assign polar_x_o        = show ? old[1] : '0;
  assign polar_y_o        = show ? old[2] : '0;
  assign polar_z_o        = show ? old[3] : '0;

endmodule

>>> rtl/core/trilinear_charge_dipole_deposit_core.sv
// A deposit runs five back-end states per grid vertex for the single-port
// cell memory read, two weight multiplies, two scaling multiplies and the write back.
// A read pops in StIdle, reads its cell in StWr and shows it in StRo; a clear
// sweeps the memory at one cell per cycle (MaxCellsX*MaxCellsY*MaxCellsZ cells, 32768 by
// default). After reset the same sweep runs with busy high; configuration writes are taken.
// The result strobe lasts one cycle and the receiver cannot stall it.
module trilinear_charge_dipole_deposit_core import tcdd_pkg::*; #(
  parameter int unsigned MaxCellsX = DefMaxCellsX,
  parameter int unsigned MaxCellsY = DefMaxCellsY,
  parameter int unsigned MaxCellsZ = DefMaxCellsZ
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        frac_x_i,
  input  logic [15:0]        frac_y_i,
  input  logic [15:0]        frac_z_i,
  input  logic signed [23:0] charge_i,
  input  logic signed [23:0] dipole_x_i,
  input  logic signed [23:0] dipole_y_i,
  input  logic signed [23:0] dipole_z_i,
  input  logic [4:0]         read_cell_x_i,
  input  logic [4:0]         read_cell_y_i,
  input  logic [4:0]         read_cell_z_i,
  output logic               result_valid_o,
  output logic signed [47:0] charge_density_o,
  output logic signed [47:0] polar_x_o,
  output logic signed [47:0] polar_y_o,
  output logic signed [47:0] polar_z_o
);

  logic [5:0]  cells_x_q, cells_y_q, cells_z_q;
  logic [31:0] inv_vol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= 6'd32;
      cells_y_q <= 6'd32;
      cells_z_q <= 6'd32;
      inv_vol_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegCellsX: cells_x_q <= cfg_wdata_i[5:0];
        RegCellsY: cells_y_q <= cfg_wdata_i[5:0];
        RegCellsZ: cells_z_q <= cfg_wdata_i[5:0];
        RegInvVol: inv_vol_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cmd_t front_cmd, head_cmd;
  logic keep, full, empty, pop, init;

  assign busy = full || init;

  tcdd_front #(.MaxCellsX(MaxCellsX), .MaxCellsY(MaxCellsY), .MaxCellsZ(MaxCellsZ)) u_front (
    .cells_x_i     (cells_x_q),
    .cells_y_i     (cells_y_q),
    .cells_z_i     (cells_z_q),
    .operation_i   (operation_i),
    .frac_x_i      (frac_x_i),
    .frac_y_i      (frac_y_i),
    .frac_z_i      (frac_z_i),
    .charge_i      (charge_i),
    .dipole_x_i    (dipole_x_i),
    .dipole_y_i    (dipole_y_i),
    .dipole_z_i    (dipole_z_i),
    .read_cell_x_i (read_cell_x_i),
    .read_cell_y_i (read_cell_y_i),
    .read_cell_z_i (read_cell_z_i),
    .keep_o        (keep),
    .cmd_o         (front_cmd)
  );

  tcdd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !busy && keep),
    .data_i  (front_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  tcdd_back #(.MaxCellsX(MaxCellsX), .MaxCellsY(MaxCellsY), .MaxCellsZ(MaxCellsZ)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .inv_cell_volume_i (inv_vol_q),
    .cmd_i             (head_cmd),
    .empty_i           (empty),
    .pop_o             (pop),
    .init_o            (init),
    .result_valid_o    (result_valid_o),
    .charge_density_o  (charge_density_o),
    .polar_x_o         (polar_x_o),
    .polar_y_o         (polar_y_o),
    .polar_z_o         (polar_z_o)
  );

endmodule

>>> rtl/core/tcdd_checker.sv
module tcdd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy,
  input logic               result_valid_o,
  input logic signed [47:0] charge_density_o,
  input logic signed [47:0] polar_x_o,
  input logic signed [47:0] polar_y_o,
  input logic signed [47:0] polar_z_o
);

  // Reset starts the clearing sweep, so no word may be taken during reset.
  a_busy_in_reset: assert property (@(posedge clk_i) !rst_ni |-> busy)
    else $error("busy low during reset");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> (charge_density_o == 48'sd0) && (polar_x_o == 48'sd0) &&
                        (polar_y_o == 48'sd0) && (polar_z_o == 48'sd0))
    else $error("result ports not quiet without strobe");

endmodule

bind trilinear_charge_dipole_deposit_core tcdd_checker u_tcdd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .busy             (busy),
  .result_valid_o   (result_valid_o),
  .charge_density_o (charge_density_o),
  .polar_x_o        (polar_x_o),
  .polar_y_o        (polar_y_o),
  .polar_z_o        (polar_z_o)
);
